### hdl/hrac_pkg.sv
// Shared types and constants for the hysteresis rule actuator control unit.
// No dependencies; hrac_csr, hrac_eval, hrac_rule and the top level refer to it by scoped names.
package hrac_pkg;

   // Width of the per-rule consecutive-sample counters (valid range 2 to 16).
   localparam int CNT_W = 8;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam int CONFIRM_W = 8;
   // Comparison width that holds both a counter and the confirm count.
   localparam int CMP_W = (CNT_W > CONFIRM_W) ? CNT_W : CONFIRM_W;

   localparam int NRULES = 4;
   localparam int RULE_TEMP = 0;
   localparam int RULE_CO2  = 1;
   localparam int RULE_SOIL = 2;
   localparam int RULE_HUM  = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AUTO_ENABLE   = 3'd0,
      CSR_TEMP_HIGH     = 3'd1,
      CSR_CO2_HIGH      = 3'd2,
      CSR_HUM_LOW       = 3'd3,
      CSR_TEMP_HYST     = 3'd4,
      CSR_CO2_HYST      = 3'd5,
      CSR_HUM_HYST      = 3'd6,
      CSR_CONFIRM_COUNT = 3'd7
   } csr_index_type;

   // Soil sensor codes; the other two codes mean no reading.
   localparam logic [1:0] SOIL_DRY = 2'd0;
   localparam logic [1:0] SOIL_WET = 2'd1;

   typedef struct packed {
      logic                        auto_enable;
      logic signed [11:0]          temp_high;
      logic [15:0]                 co2_high;
      logic [9:0]                  hum_low;
      logic [7:0]                  temp_hyst;
      logic [13:0]                 co2_hyst;
      logic [8:0]                  hum_hyst;
      logic [CONFIRM_W-1:0]        confirm_count;
   } cfg_type;

   typedef struct packed {
      logic               has_data;
      logic signed [11:0] temperature;
      logic               temp_valid;
      logic [15:0]        co2_ppm;
      logic               co2_valid;
      logic [9:0]         humidity;
      logic               hum_valid;
      logic [1:0]         soil_code;
   } sample_type;

   typedef struct packed {
      logic fan_on;
      logic pump_on;
      logic fan_changed;
      logic pump_changed;
      logic [NRULES-1:0] active_mask;
   } result_type;

   // Classification of one sample for one rule.
   typedef struct packed {
      logic over;
      logic safe;
   } rule_cmd_type;

   // Activity of one rule: registered value and value after this sample.
   typedef struct packed {
      logic active;
      logic active_next;
   } rule_stat_type;

endpackage

### hdl/hrac_req_if.sv
// Input channel of the hysteresis rule actuator control unit: one sample per transaction.
// Depends on nothing else.
interface hrac_req_if;
   logic               valid;
   logic               ready;
   logic               has_data;
   logic signed [11:0] temperature;
   logic               temp_valid;
   logic [15:0]        co2_ppm;
   logic               co2_valid;
   logic [9:0]         humidity;
   logic               hum_valid;
   logic [1:0]         soil_code;

   modport source (output valid, has_data, temperature, temp_valid, co2_ppm, co2_valid,
                   humidity, hum_valid, soil_code, input ready);
   modport sink   (input valid, has_data, temperature, temp_valid, co2_ppm, co2_valid,
                   humidity, hum_valid, soil_code, output ready);
endinterface

### hdl/hrac_rsp_if.sv
// Result channel of the hysteresis rule actuator control unit: one report of actuator
// changes per transaction. Depends on nothing else.
interface hrac_rsp_if;
   logic       valid;
   logic       ready;
   logic       fan_on;
   logic       pump_on;
   logic       fan_changed;
   logic       pump_changed;
   logic [3:0] active_mask;

   modport source (output valid, fan_on, pump_on, fan_changed, pump_changed, active_mask,
                   input ready);
   modport sink   (input valid, fan_on, pump_on, fan_changed, pump_changed, active_mask,
                   output ready);
endinterface

### hdl/hrac_csr.sv
// Configuration register file for the hysteresis rule actuator control unit.
// Depends on hrac_pkg.
module hrac_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [hrac_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hrac_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output hrac_pkg::cfg_type                   cfg
);

   hrac_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            hrac_pkg::CSR_AUTO_ENABLE:   cfg_in.auto_enable   = csr_wdata[0];
            hrac_pkg::CSR_TEMP_HIGH:     cfg_in.temp_high     = csr_wdata[11:0];
            hrac_pkg::CSR_CO2_HIGH:      cfg_in.co2_high      = csr_wdata[15:0];
            hrac_pkg::CSR_HUM_LOW:       cfg_in.hum_low       = csr_wdata[9:0];
            hrac_pkg::CSR_TEMP_HYST:     cfg_in.temp_hyst     = csr_wdata[7:0];
            hrac_pkg::CSR_CO2_HYST:      cfg_in.co2_hyst      = csr_wdata[13:0];
            hrac_pkg::CSR_HUM_HYST:      cfg_in.hum_hyst      = csr_wdata[8:0];
            hrac_pkg::CSR_CONFIRM_COUNT: cfg_in.confirm_count = csr_wdata[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_enable   <= 1'b1;
         cfg_ff.temp_high     <= 12'sd300;
         cfg_ff.co2_high      <= 16'd1500;
         cfg_ff.hum_low       <= 10'd400;
         cfg_ff.temp_hyst     <= 8'd10;
         cfg_ff.co2_hyst      <= 14'd100;
         cfg_ff.hum_hyst      <= 9'd50;
         cfg_ff.confirm_count <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/hrac_eval.sv
// Threshold and hysteresis comparisons that classify one sample for each of the four rules.
// Depends on hrac_pkg.
module hrac_eval (
   input  hrac_pkg::sample_type   sample,
   input  hrac_pkg::cfg_type      cfg,
   output hrac_pkg::rule_cmd_type cmd [hrac_pkg::NRULES]
);

   logic signed [12:0] temp_safe_lim;
   logic [16:0]        co2_plus_hyst;
   logic [10:0]        hum_safe_lim;

   always_comb begin
      // Safe band lies hysteresis below the threshold; 13 bits hold the lowest limit.
      temp_safe_lim = 13'(cfg.temp_high) - $signed({5'd0, cfg.temp_hyst});
      // co2 <= high - hyst rewritten as co2 + hyst <= high, so a threshold below
      // the hysteresis simply never reports safe.
      co2_plus_hyst = {1'b0, sample.co2_ppm} + {3'd0, cfg.co2_hyst};
      hum_safe_lim  = {1'b0, cfg.hum_low} + {2'd0, cfg.hum_hyst};

      cmd[hrac_pkg::RULE_TEMP].over = sample.temp_valid && (sample.temperature >= cfg.temp_high);
      cmd[hrac_pkg::RULE_TEMP].safe = sample.temp_valid &&
                                      (13'(sample.temperature) <= temp_safe_lim);

      cmd[hrac_pkg::RULE_CO2].over  = sample.co2_valid && (sample.co2_ppm >= cfg.co2_high);
      cmd[hrac_pkg::RULE_CO2].safe  = sample.co2_valid &&
                                      (co2_plus_hyst <= {1'b0, cfg.co2_high});

      cmd[hrac_pkg::RULE_SOIL].over = (sample.soil_code == hrac_pkg::SOIL_DRY);
      cmd[hrac_pkg::RULE_SOIL].safe = (sample.soil_code == hrac_pkg::SOIL_WET);

      cmd[hrac_pkg::RULE_HUM].over  = sample.hum_valid && (sample.humidity < cfg.hum_low);
      cmd[hrac_pkg::RULE_HUM].safe  = sample.hum_valid &&
                                      ({1'b0, sample.humidity} >= hum_safe_lim);
   end

endmodule

### hdl/hrac_rule.sv
// One rule: saturating over and safe counters with confirmation and the activity flag.
// Depends on hrac_pkg.
module hrac_rule (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  update,
   input  hrac_pkg::rule_cmd_type                cmd,
   input  logic [hrac_pkg::CONFIRM_W-1:0]        confirm_count,
   output hrac_pkg::rule_stat_type               stat
);

   logic [hrac_pkg::CNT_W-1:0] over_ff, over_in, over_nx;
   logic [hrac_pkg::CNT_W-1:0] safe_ff, safe_in, safe_nx;
   logic                       active_ff, active_in, active_nx;
   logic [hrac_pkg::CMP_W-1:0] confirm_ext;

   always_comb begin
      over_nx     = over_ff;
      safe_nx     = safe_ff;
      active_nx   = active_ff;
      confirm_ext = hrac_pkg::CMP_W'(confirm_count);
      if (cmd.over) begin
         over_nx = (over_ff == hrac_pkg::CNT_MAX) ? over_ff
                                                  : over_ff + hrac_pkg::CNT_W'(1);
         safe_nx = '0;
      end else if (cmd.safe) begin
         safe_nx = (safe_ff == hrac_pkg::CNT_MAX) ? safe_ff
                                                  : safe_ff + hrac_pkg::CNT_W'(1);
         over_nx = '0;
      end
      // A sample that is neither over nor safe leaves activity alone.
      if (cmd.over || cmd.safe) begin
         if (!active_ff && (hrac_pkg::CMP_W'(over_nx) >= confirm_ext)) begin
            active_nx = 1'b1;
         end else if (active_ff && (hrac_pkg::CMP_W'(safe_nx) >= confirm_ext)) begin
            active_nx = 1'b0;
         end
      end
   end

   always_comb begin
      over_in   = update ? over_nx   : over_ff;
      safe_in   = update ? safe_nx   : safe_ff;
      active_in = update ? active_nx : active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         over_ff   <= '0;
         safe_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         over_ff   <= over_in;
         safe_ff   <= safe_in;
         active_ff <= active_in;
      end
   end

   assign stat.active      = active_ff;
   assign stat.active_next = active_nx;

endmodule

### hdl/hysteresis_rule_actuator_control_unit.sv
// Hysteresis rule actuator control unit, top level.
// A sample passes through the sample register and, if it flips an actuator, the result register.
// Throughput: one sample per cycle while the result side keeps up; the sample register and
// the result register each take one transaction, and all four rules update together.
// Reset (synchronous, active high) clears counters, rule flags, actuator states and both
// handshake stages, and loads the configuration registers with their default values.
module hysteresis_rule_actuator_control_unit (
   input  logic                            clock,
   input  logic                            reset,
   hrac_req_if.sink                        req_bus,
   hrac_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [hrac_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hrac_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers. Writes must arrive only while the unit is idle; the
   // block does not enforce this, and the rule logic reads them directly.
   // ------------------------------------------------------------------
   hrac_pkg::cfg_type cfg;

   hrac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ------------------------------------------------------------------
   // Sample register. A transaction is taken whenever the register is empty
   // or its content moves on in this same cycle.
   // ------------------------------------------------------------------
   logic                 smp_valid_ff, smp_valid_in;
   hrac_pkg::sample_type smp_ff, smp_in;
   logic                 advance;
   logic                 req_fire;

   // Result register.
   logic                 res_valid_ff, res_valid_in;
   hrac_pkg::result_type res_ff, res_in;

   // Actuator states as last reported.
   logic fan_ff, fan_in;
   logic pump_ff, pump_in;

   // The sample in the register is evaluated when the result register can take
   // whatever it produces: empty, or drained at this edge.
   assign advance  = smp_valid_ff && (!res_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !smp_valid_ff || advance;
   assign req_fire = req_bus.valid && req_bus.ready;

   always_comb begin
      smp_in.has_data    = req_bus.has_data;
      smp_in.temperature = req_bus.temperature;
      smp_in.temp_valid  = req_bus.temp_valid;
      smp_in.co2_ppm     = req_bus.co2_ppm;
      smp_in.co2_valid   = req_bus.co2_valid;
      smp_in.humidity    = req_bus.humidity;
      smp_in.hum_valid   = req_bus.hum_valid;
      smp_in.soil_code   = req_bus.soil_code;
      if (req_fire) begin
         smp_valid_in = 1'b1;
      end else if (advance) begin
         smp_valid_in = 1'b0;
      end else begin
         smp_valid_in = smp_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Rule evaluation. In manual mode, or when the sample carries no snapshot,
   // the sample is consumed without touching any state.
   // ------------------------------------------------------------------
   hrac_pkg::rule_cmd_type  cmd  [hrac_pkg::NRULES];
   hrac_pkg::rule_stat_type stat [hrac_pkg::NRULES];
   logic                    rule_update;
   logic [hrac_pkg::NRULES-1:0] act_next;

   assign rule_update = advance && cfg.auto_enable && smp_ff.has_data;

   hrac_eval u_eval (
      .sample (smp_ff),
      .cfg    (cfg),
      .cmd    (cmd)
   );

   for (genvar r = 0; r < hrac_pkg::NRULES; r++) begin : g_rule
      hrac_rule u_rule (
         .clock         (clock),
         .reset         (reset),
         .update        (rule_update),
         .cmd           (cmd[r]),
         .confirm_count (cfg.confirm_count),
         .stat          (stat[r])
      );
      assign act_next[r] = stat[r].active_next;
   end

   // ------------------------------------------------------------------
   // Actuator combination and change detection. The fan follows the
   // temperature and CO2 rules, the pump the soil and humidity rules; a
   // result transaction is produced only when one of them flips.
   // ------------------------------------------------------------------
   logic fan_nx, pump_nx, emit;

   always_comb begin
      fan_nx  = act_next[hrac_pkg::RULE_TEMP] || act_next[hrac_pkg::RULE_CO2];
      pump_nx = act_next[hrac_pkg::RULE_SOIL] || act_next[hrac_pkg::RULE_HUM];
      emit    = rule_update && ((fan_nx != fan_ff) || (pump_nx != pump_ff));

      res_in.fan_on       = fan_nx;
      res_in.pump_on      = pump_nx;
      res_in.fan_changed  = (fan_nx != fan_ff);
      res_in.pump_changed = (pump_nx != pump_ff);
      res_in.active_mask  = act_next;

      fan_in  = emit ? fan_nx  : fan_ff;
      pump_in = emit ? pump_nx : pump_ff;

      if (advance) begin
         res_valid_in = emit;
      end else if (rsp_bus.ready) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
         fan_ff       <= 1'b0;
         pump_ff      <= 1'b0;
      end else begin
         smp_valid_ff <= smp_valid_in;
         res_valid_ff <= res_valid_in;
         fan_ff       <= fan_in;
         pump_ff      <= pump_in;
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         smp_ff <= smp_in;
      end
      if (emit) begin
         res_ff <= res_in;
      end
   end

   assign rsp_bus.valid        = res_valid_ff;
   assign rsp_bus.fan_on       = res_ff.fan_on;
   assign rsp_bus.pump_on      = res_ff.pump_on;
   assign rsp_bus.fan_changed  = res_ff.fan_changed;
   assign rsp_bus.pump_changed = res_ff.pump_changed;
   assign rsp_bus.active_mask  = res_ff.active_mask;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // Every result transaction reports at least one actuator flip.
   a_result_has_change : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.fan_changed || rsp_bus.pump_changed))
      else $error("result transaction without an actuator change");

   // A pending result matches the recorded actuator states.
   a_result_tracks_state : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ((rsp_bus.fan_on == fan_ff) && (rsp_bus.pump_on == pump_ff)))
      else $error("pending result disagrees with actuator state");

   // Fan and pump in a result are the OR of their rule groups in the mask.
   a_result_mask_consistent : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ((rsp_bus.fan_on == (rsp_bus.active_mask[0] || rsp_bus.active_mask[1]))
                      && (rsp_bus.pump_on == (rsp_bus.active_mask[2] || rsp_bus.active_mask[3]))))
      else $error("result actuator bits disagree with active mask");

   // Rule state only moves for a held sample that can hand off its result.
   a_update_needs_room : assert property (@(posedge clock) disable iff (reset)
      rule_update |-> (smp_valid_ff && (!res_valid_ff || rsp_bus.ready)))
      else $error("rule update without a sample or result room");

endmodule
